[hw/rtl/dtsw_pkg.sv]
`timescale 1ns / 1ps

package dtsw_pkg;

  localparam int GAIN_W    = 24;
  localparam int SHAPE_W   = 17;
  localparam int INV_W     = 17;
  localparam int VOL_W     = 18;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  // tanh argument is Q4.16 clamped to 8.0, table values are Q1.16 up to 1.0
  localparam int ARG_W  = 20;
  localparam int TANH_W = 17;
  localparam int FRAC_W = 16;

  localparam logic [TANH_W-1:0] ONE_Q16 = 17'd65536;
  localparam logic [ARG_W-1:0]  ARG_MAX = 20'd524288;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRE_GAIN     = 2'd0,
    REG_BLEND_SHAPE  = 2'd1,
    REG_INV_SOFTNESS = 2'd2,
    REG_OUT_VOLUME   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  pre_gain;
    logic [SHAPE_W-1:0] blend_shape;
    logic [INV_W-1:0]   inv_softness;
    logic [VOL_W-1:0]   out_volume;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    pre_gain:     24'd12255232,
    blend_shape:  17'd24248,
    inv_softness: 17'd7802,
    out_volume:   18'd655
  };

endpackage

[hw/rtl/dual_tanh_soft_clip_waveshaper.sv]
`timescale 1ns / 1ps

// channel   | handshake            | payload
// ----------+----------------------+-------------------------------------
// config    | cfg_wr_en            | cfg_index[1:0], cfg_data[23:0]
// input     | in_valid / in_ready  | sample_in[SAMPLE_BITS-1:0], signed
// output    | out_valid / out_ready| sample_out[SAMPLE_BITS-1:0], clipped
//
// One item per cycle sustained while out_ready is high; each item passes through the stage pipeline.
// The two tanh lookups share one constant table with two registered read ports.
// Each stage holds only when it is full and the stage after it is blocked,
// so input is refused only when every stage carries an item.
// rst clears the stage valid bits and loads the register defaults; the table needs no fill.

module dual_tanh_soft_clip_waveshaper #(
  parameter int SAMPLE_BITS      = 24,
  parameter int TANH_TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [dtsw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dtsw_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       sample_out,
  output logic                                clipped
);

  dtsw_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= dtsw_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      unique case (dtsw_pkg::reg_idx_t'(cfg_index))
        dtsw_pkg::REG_PRE_GAIN:     cfg.pre_gain     <= cfg_data;
        dtsw_pkg::REG_BLEND_SHAPE:  cfg.blend_shape  <= cfg_data[dtsw_pkg::SHAPE_W-1:0];
        dtsw_pkg::REG_INV_SOFTNESS: cfg.inv_softness <= cfg_data[dtsw_pkg::INV_W-1:0];
        dtsw_pkg::REG_OUT_VOLUME:   cfg.out_volume   <= cfg_data[dtsw_pkg::VOL_W-1:0];
      endcase
    end
  end

  dtsw_core #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .clipped    (clipped)
  );

endmodule

[hw/rtl/dtsw_core.sv]
`timescale 1ns / 1ps

module dtsw_core #(
  parameter int SAMPLE_BITS      = 24,
  parameter int TANH_TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dtsw_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          clipped
);

  localparam int SB      = SAMPLE_BITS;
  localparam int NS      = 12;
  localparam int TW      = dtsw_pkg::TANH_W;
  localparam int FW      = dtsw_pkg::FRAC_W;
  localparam int AGW     = dtsw_pkg::ARG_W;
  localparam int IDX_W   = $clog2(TANH_TABLE_DEPTH + 1);
  localparam int ROM_W   = 2 * TW;
  localparam int PROD_W  = SB + dtsw_pkg::GAIN_W;
  localparam int A_W     = dtsw_pkg::GAIN_W + 3;
  localparam int BP_W    = A_W + dtsw_pkg::INV_W;
  localparam int B_W     = BP_W - FW;
  localparam int K_W     = AGW + IDX_W;
  localparam int LP_W    = TW + FW;
  localparam int MIX_W   = 2 * TW - 1;
  localparam int PV_W    = MIX_W + dtsw_pkg::VOL_W;
  localparam int SH      = 49 - SB;
  localparam int MAG_W   = PV_W + 1 - SH;

  localparam logic [SB-1:0]    ONE_SB     = SB'(1);
  localparam logic [SB-1:0]    S_MAX      = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0]    S_MIN      = {1'b1, {(SB-1){1'b0}}};
  localparam logic [MAG_W-1:0] HALF_MAG   = MAG_W'(1) << (SB - 1);
  localparam logic [MAG_W-1:0] POS_LIM    = HALF_MAG - MAG_W'(1);
  localparam logic [PV_W:0]    ROUND_HALF = (PV_W + 1)'(1) << (SH - 1);
  localparam logic [LP_W-1:0]  LERP_HALF  = LP_W'(1) << (FW - 1);
  localparam logic [K_W-1:0]   DEPTH_K    = K_W'(TANH_TABLE_DEPTH);

  localparam logic [63:0] ROM_ONE = 64'd1 << 30;
  localparam logic [63:0] H_STEP  = (64'd1 << 34) / 64'(TANH_TABLE_DEPTH);

  // word i holds {max(tanh[i+1], tanh[i]), tanh[i]}, the last word repeats the end point
  typedef logic [TANH_TABLE_DEPTH:0][ROM_W-1:0] rom_img_t;

  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic rom_img_t build_rom();
    rom_img_t    img;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] val;
    logic [63:0] prev;
    img  = '0;
    term = ROM_ONE;
    pos  = ROM_ONE;
    neg  = '0;
    prev = '0;
    // e^(-16/depth) by a nine-term Taylor sum in Q.30
    for (int k = 1; k <= 8; k++) begin
      term = udiv((term * H_STEP) >> 30, 64'(k));
      if (k % 2 == 1) neg = neg + term;
      else pos = pos + term;
    end
    r = pos - neg;
    e = ROM_ONE;
    for (int i = 0; i <= TANH_TABLE_DEPTH; i++) begin
      if (i > 0) e = (e * r + (ROM_ONE >> 1)) >> 30;
      val = udiv(((ROM_ONE - e) << 16) + ((ROM_ONE + e) >> 1), ROM_ONE + e);
      img[i][TW-1:0] = val[TW-1:0];
      if (i > 0) img[i-1][ROM_W-1:TW] = (val < prev) ? prev[TW-1:0] : val[TW-1:0];
      if (i == TANH_TABLE_DEPTH) img[i][ROM_W-1:TW] = val[TW-1:0];
      prev = val;
    end
    return img;
  endfunction

  localparam rom_img_t ROM_IMG = build_rom();

  // ---------------- stage control ----------------
  logic [NS:1]   v;
  logic [NS-1:0] v_src;
  logic [NS+1:1] en;

  assign v_src = {v[NS-1:1], in_valid};

  always_comb begin
    en[NS+1] = out_ready;
    for (int k = NS; k >= 1; k--) en[k] = ~v[k] | en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (en[k]) v[k] <= v_src[k-1];
      end
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v[NS];

  // ---------------- config decode ----------------
  logic [TW-1:0] shp;
  logic [TW-1:0] shp_inv;
  logic [TW-1:0] inv_c;

  assign shp     = (cfg.blend_shape > dtsw_pkg::ONE_Q16) ? dtsw_pkg::ONE_Q16 : cfg.blend_shape;
  assign shp_inv = dtsw_pkg::ONE_Q16 - shp;
  assign inv_c   = (cfg.inv_softness > dtsw_pkg::ONE_Q16) ? dtsw_pkg::ONE_Q16
                                                          : cfg.inv_softness;

  // ---------------- datapath ----------------
  logic [SB-1:0]     x0;
  logic [SB-1:0]     m1;
  logic [PROD_W-1:0] p2;
  logic [A_W-1:0]    a3_raw;
  logic [AGW-1:0]    a_c3, a_c4;
  logic [BP_W-1:0]   bp3;
  logic [B_W-1:0]    b4_raw;
  logic [AGW-1:0]    b_c4;
  logic [K_W-1:0]    ka5, kb5;
  logic [ROM_W-1:0]  qa6, qb6;
  logic [FW-1:0]     fa6, fb6, fa7, fb7;
  logic [TW-1:0]     loa7, lob7, da7, db7;
  logic [LP_W-1:0]   lpa8, lpb8;
  logic [TW-1:0]     ta8, tb8;
  logic [MIX_W-1:0]  mix9;
  logic [PV_W-1:0]   pv10;
  logic [PV_W:0]     rsum;
  logic [MAG_W-1:0]  mag11;
  logic [NS-1:1]     n;

  assign x0     = sample_in;
  assign a3_raw = p2[PROD_W-1:SB-3];
  assign b4_raw = bp3[BP_W-1:FW];
  assign lpa8   = LP_W'(da7) * LP_W'(fa7) + LERP_HALF;
  assign lpb8   = LP_W'(db7) * LP_W'(fb7) + LERP_HALF;
  assign rsum   = {1'b0, pv10} + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      m1   <= x0[SB-1] ? (~x0 + ONE_SB) : x0;
      n[1] <= x0[SB-1];
    end
    if (en[2]) begin
      p2   <= PROD_W'(m1) * PROD_W'(cfg.pre_gain);
      n[2] <= n[1];
    end
    if (en[3]) begin
      a_c3 <= (a3_raw > A_W'(dtsw_pkg::ARG_MAX)) ? dtsw_pkg::ARG_MAX : a3_raw[AGW-1:0];
      bp3  <= BP_W'(a3_raw) * BP_W'(inv_c);
      n[3] <= n[2];
    end
    if (en[4]) begin
      a_c4 <= a_c3;
      b_c4 <= (b4_raw > B_W'(dtsw_pkg::ARG_MAX)) ? dtsw_pkg::ARG_MAX : b4_raw[AGW-1:0];
      n[4] <= n[3];
    end
    if (en[5]) begin
      ka5  <= K_W'(a_c4) * DEPTH_K;
      kb5  <= K_W'(b_c4) * DEPTH_K;
      n[5] <= n[4];
    end
    // table read: index is k >> 19, fraction is bits 18:3
    if (en[6]) begin
      qa6  <= ROM_IMG[ka5[19 +: IDX_W]];
      qb6  <= ROM_IMG[kb5[19 +: IDX_W]];
      fa6  <= ka5[18:3];
      fb6  <= kb5[18:3];
      n[6] <= n[5];
    end
    if (en[7]) begin
      loa7 <= qa6[TW-1:0];
      lob7 <= qb6[TW-1:0];
      da7  <= qa6[ROM_W-1:TW] - qa6[TW-1:0];
      db7  <= qb6[ROM_W-1:TW] - qb6[TW-1:0];
      fa7  <= fa6;
      fb7  <= fb6;
      n[7] <= n[6];
    end
    if (en[8]) begin
      ta8  <= loa7 + lpa8[LP_W-1:FW];
      tb8  <= lob7 + lpb8[LP_W-1:FW];
      n[8] <= n[7];
    end
    if (en[9]) begin
      mix9 <= MIX_W'(shp_inv) * MIX_W'(ta8) + MIX_W'(shp) * MIX_W'(tb8);
      n[9] <= n[8];
    end
    if (en[10]) begin
      pv10  <= PV_W'(mix9) * PV_W'(cfg.out_volume);
      n[10] <= n[9];
    end
    if (en[11]) begin
      mag11 <= rsum[PV_W:SH];
      n[11] <= n[10];
    end
    // output register: saturate and restore sign
    if (en[12]) begin
      if (n[11]) begin
        if (mag11 > HALF_MAG) begin
          sample_out <= S_MIN;
          clipped    <= 1'b1;
        end else begin
          sample_out <= ~mag11[SB-1:0] + ONE_SB;
          clipped    <= 1'b0;
        end
      end else begin
        if (mag11 > POS_LIM) begin
          sample_out <= S_MAX;
          clipped    <= 1'b1;
        end else begin
          sample_out <= mag11[SB-1:0];
          clipped    <= 1'b0;
        end
      end
    end
  end

  // ---------------- checks ----------------
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&v))
    else $error("input stalled with an empty stage");

  a_args_clamped: assert property (@(posedge clk) disable iff (rst)
    v[4] |-> (a_c4 <= dtsw_pkg::ARG_MAX) && (b_c4 <= dtsw_pkg::ARG_MAX))
    else $error("tanh argument beyond 8.0");

  a_tanh_range: assert property (@(posedge clk) disable iff (rst)
    v[8] |-> (ta8 <= dtsw_pkg::ONE_Q16) && (tb8 <= dtsw_pkg::ONE_Q16))
    else $error("interpolated tanh above 1.0");

  a_clip_at_rail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |-> (sample_out == S_MAX || sample_out == S_MIN))
    else $error("clipped item not at a rail");

endmodule
